FILE: src/assert_macros.svh
// Assertion macros shared by the rotor step RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: src/rsbf_pkg.sv
// Shared types and constants for the rotor step block.
// No dependencies.
`default_nettype none

package rsbf_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Inverse in GF(16), polynomial x^4+x+1, with inv(0) = 0.
  function automatic logic [3:0] gf16_inv(input logic [3:0] v);
    logic [3:0] r;
    unique case (v)
      4'h0: r = 4'h0;
      4'h1: r = 4'h1;
      4'h2: r = 4'h9;
      4'h3: r = 4'hE;
      4'h4: r = 4'hD;
      4'h5: r = 4'hB;
      4'h6: r = 4'h7;
      4'h7: r = 4'h6;
      4'h8: r = 4'hF;
      4'h9: r = 4'h2;
      4'hA: r = 4'hC;
      4'hB: r = 4'h5;
      4'hC: r = 4'hA;
      4'hD: r = 4'h4;
      4'hE: r = 4'h3;
      default: r = 4'h8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/rotor_step_bent_function.sv
// Top level of the rotor step block: rotor byte store, command stage, result stage.
// Depends on rsbf_pkg, rsbf_step and assert_macros.svh.
`default_nettype none

//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | command, rotor_index, write_value
//  out     | out_valid / out_ready | read_value
//
// One word in, one word out. A word is latched in the command register,
// then applied to the rotor bytes while its read_value goes into the
// result register; one word per cycle while out_ready holds high.
// The step is one pass of 16-entry lookups, 4-bit parities and adds.
// Reset (rst, synchronous) clears all rotor bytes and both valid flags.
// A stalled result register holds the command register, and in_ready
// drops only when both are full.

module rotor_step_bent_function
  import rsbf_pkg::*;
#(
  parameter int ROTOR_COUNT = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic [4:0] rotor_index,
  input  wire logic [7:0] write_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] read_value
);

  localparam int IdxW = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;

  // rotor byte store
  logic [ROTOR_COUNT-1:0][7:0] rotors;
  logic [ROTOR_COUNT-1:0][7:0] rotors_next;
  logic [ROTOR_COUNT-1:0][7:0] stepped;

  // command register
  logic       s1_valid;
  cmd_t       s1_command;
  logic [4:0] s1_index;
  logic [7:0] s1_value;
  logic       s1_fire;

  logic [6:0]      idx_wide;
  logic [IdxW-1:0] idx;
  logic            idx_ok;
  logic [7:0]      read_value_next;

  // command register leaving this cycle, by kind
  logic fire_step;
  logic fire_write;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  assign fire_step  = s1_fire && (s1_command == CMD_STEP);
  assign fire_write = s1_fire && (s1_command == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_command <= cmd_t'(command);
      s1_index   <= rotor_index;
      s1_value   <= write_value;
    end
  end

  // index beyond the rotors: writes dropped, reads give zero
  assign idx_wide = {2'b00, s1_index};
  assign idx      = idx_wide[IdxW-1:0];
  assign idx_ok   = idx_wide < 7'(ROTOR_COUNT);

  rsbf_step #(
    .ROTOR_COUNT(ROTOR_COUNT)
  ) u_step (
    .rotors (rotors),
    .stepped(stepped)
  );

  always_comb begin
    rotors_next = rotors;
    if (s1_fire) begin
      unique case (s1_command)
        CMD_WRITE: begin
          if (idx_ok) begin
            rotors_next[idx] = s1_value;
          end
        end
        CMD_STEP: begin
          rotors_next = stepped;
        end
        default: begin
          // read, and the unused code, leave the bytes alone
        end
      endcase
    end
  end

  // value after the command has taken effect
  assign read_value_next = idx_ok ? rotors_next[idx] : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotors <= '0;
    end else begin
      rotors <= rotors_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_value <= read_value_next;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !s1_valid && !out_valid)
  `ASSERT_CLK(a_stall_full, !in_ready |-> s1_valid && out_valid && !out_ready)
  `ASSERT_CLK(a_step_byte0, fire_step |=> rotors[0] == $past(rotors[0]) + 8'd1)
  `ASSERT_CLK(a_read_keeps, s1_fire && s1_command == CMD_READ |=> $stable(rotors))
  `ASSERT_CLK(a_write_echo, fire_write && idx_ok |=> out_valid && read_value == $past(s1_value))

endmodule

`default_nettype wire

FILE: src/rsbf_step.sv
// Combinational step of all rotor bytes: lane parities and constant adds.
// Depends on rsbf_pkg (gf16_inv).
`default_nettype none

module rsbf_step
  import rsbf_pkg::*;
#(
  parameter int ROTOR_COUNT = 32
) (
  input  wire logic [ROTOR_COUNT-1:0][7:0] rotors,
  output logic      [ROTOR_COUNT-1:0][7:0] stepped
);

  logic [ROTOR_COUNT-1:0] parity;

  for (genvar i = 0; i < ROTOR_COUNT; i++) begin : g_lane
    localparam int LoByte = i / 2;
    localparam int LoHalf = i % 2;
    localparam int HiNib  = 2 * ROTOR_COUNT - 1 - i;
    localparam int HiByte = HiNib / 2;
    localparam int HiHalf = HiNib % 2;
    localparam logic [7:0] Inc = 8'((2 * i + 1) % 256);

    logic [3:0] nib_a;
    logic [3:0] nib_b;

    assign nib_a = (LoHalf != 0) ? rotors[LoByte][7:4] : rotors[LoByte][3:0];
    assign nib_b = (HiHalf != 0) ? rotors[HiByte][7:4] : rotors[HiByte][3:0];
    assign parity[i] = ^(gf16_inv(nib_a) & nib_b);

    // lane 0 always matches itself, so it always gains 1
    assign stepped[i] = (parity[i] == parity[0]) ? rotors[i] + Inc : rotors[i];
  end

endmodule

`default_nettype wire
